// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker in fpt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk and muted while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Concurrent assertion sampled on clk that also covers the reset cycles.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== sv/fpt_pkg.sv =====
// Package for the friendly pair test unit: widths, types, states and helpers.
package fpt_pkg;

    localparam int NUMBER_BITS = 16;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 18;
    localparam int SUM_W       = NUMBER_BITS + 3;
    localparam int PROD_W      = SUM_W + NUMBER_BITS;
    localparam int CNT_W       = $clog2(NUMBER_BITS + 1);
    localparam int CMP_W       = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam logic [OUT_W-1:0] SUM_MAX = {OUT_W{1'b1}};

    typedef logic [NUMBER_BITS-1:0] t_num;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [PROD_W-1:0]      t_prod;
    typedef logic [OUT_W-1:0]       t_out_sum;

    typedef struct packed {
        logic done;
        t_num quotient;
        t_num remainder;
    } t_div_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_NEXT,
        ST_MUL_A,
        ST_MUL_B,
        ST_DONE
    } t_state;

    // Clamp a divisor sum to the output field range.
    function automatic t_out_sum sat_sum(input t_sum s);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(s);
        if (wide > CMP_W'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return OUT_W'(wide);
    endfunction

endpackage

// ===== sv/friendly_pair_test_unit.sv =====
// Top level of the friendly pair test unit: sequencer, sum accumulation, cross check.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_ready  i_first_number, i_second_number
//   result   out        o_valid / i_ready  o_first_divisor_sum, o_second_divisor_sum,
//                                          o_is_friendly
//
// Flow: each number n runs floor(sqrt(n)) + 1 trial divisions on the shared divider
// (start, bit steps, done), at most 256 for 16-bit inputs; a zero input skips them.
// Then come two sum hand-offs, two multiplies and the compare. Reset is synchronous,
// active low: it idles the sequencer and drops any pending result. A stalled result
// holds in the output register; the next pair transfers in and waits in the final
// state meanwhile.
module friendly_pair_test_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fpt_pkg::IN_W-1:0]    i_first_number,
    input  logic [fpt_pkg::IN_W-1:0]    i_second_number,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fpt_pkg::OUT_W-1:0]   o_first_divisor_sum,
    output logic [fpt_pkg::OUT_W-1:0]   o_second_divisor_sum,
    output logic                        o_is_friendly
);

    fpt_pkg::t_state   r_state, n_state;
    fpt_pkg::t_num     r_a, n_a;
    fpt_pkg::t_num     r_b, n_b;
    fpt_pkg::t_num     r_d, n_d;
    logic              r_sel, n_sel;
    fpt_pkg::t_sum     r_acc, n_acc;
    fpt_pkg::t_sum     r_sa, n_sa;
    fpt_pkg::t_sum     r_sb, n_sb;
    fpt_pkg::t_prod    r_pa, n_pa;
    fpt_pkg::t_prod    r_pb, n_pb;
    logic              r_out_valid, n_out_valid;
    fpt_pkg::t_out_sum r_out_sa, n_out_sa;
    fpt_pkg::t_out_sum r_out_sb, n_out_sb;
    logic              r_out_fr, n_out_fr;

    logic              div_start;
    fpt_pkg::t_div_res div_res;
    fpt_pkg::t_num     cur_n;
    fpt_pkg::t_sum     mul_x;
    fpt_pkg::t_num     mul_y;
    fpt_pkg::t_prod    mul_p;

    assign cur_n = r_sel ? r_b : r_a;

    // One multiplier serves both cross products.
    assign mul_x = (r_state == fpt_pkg::ST_MUL_A) ? r_sa : r_sb;
    assign mul_y = (r_state == fpt_pkg::ST_MUL_A) ? r_b : r_a;
    assign mul_p = fpt_pkg::PROD_W'(mul_x) * fpt_pkg::PROD_W'(mul_y);

    fpt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur_n),
        .i_divisor  (r_d),
        .o_res      (div_res)
    );

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_d         = r_d;
        n_sel       = r_sel;
        n_acc       = r_acc;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_out_valid = r_out_valid;
        n_out_sa    = r_out_sa;
        n_out_sb    = r_out_sb;
        n_out_fr    = r_out_fr;
        div_start   = 1'b0;
        o_ready     = 1'b0;

        // Drop the result once the downstream side takes it.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fpt_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    // Keep only the low NUMBER_BITS bits of each number.
                    n_a     = fpt_pkg::NUMBER_BITS'(i_first_number);
                    n_b     = fpt_pkg::NUMBER_BITS'(i_second_number);
                    n_sel   = 1'b0;
                    n_d     = fpt_pkg::NUMBER_BITS'(1);
                    n_acc   = '0;
                    n_state = fpt_pkg::ST_LOAD;
                end
            end
            fpt_pkg::ST_LOAD: begin
                if (cur_n == '0) begin
                    n_state = fpt_pkg::ST_NEXT;
                end else begin
                    div_start = 1'b1;
                    n_state   = fpt_pkg::ST_DIV;
                end
            end
            fpt_pkg::ST_DIV: begin
                if (div_res.done) begin
                    if (div_res.quotient < r_d) begin
                        // Past the square root: this sum is complete.
                        n_state = fpt_pkg::ST_NEXT;
                    end else begin
                        if (div_res.remainder == '0) begin
                            // Add d and its cofactor, once for a perfect square.
                            n_acc = r_acc + fpt_pkg::SUM_W'(r_d)
                                  + ((div_res.quotient != r_d)
                                     ? fpt_pkg::SUM_W'(div_res.quotient) : '0);
                        end
                        n_d     = r_d + 1'b1;
                        n_state = fpt_pkg::ST_LOAD;
                    end
                end
            end
            fpt_pkg::ST_NEXT: begin
                if (!r_sel) begin
                    n_sa    = r_acc;
                    n_sel   = 1'b1;
                    n_d     = fpt_pkg::NUMBER_BITS'(1);
                    n_acc   = '0;
                    n_state = fpt_pkg::ST_LOAD;
                end else begin
                    n_sb    = r_acc;
                    n_state = fpt_pkg::ST_MUL_A;
                end
            end
            fpt_pkg::ST_MUL_A: begin
                n_pa    = mul_p;
                n_state = fpt_pkg::ST_MUL_B;
            end
            fpt_pkg::ST_MUL_B: begin
                n_pb    = mul_p;
                n_state = fpt_pkg::ST_DONE;
            end
            fpt_pkg::ST_DONE: begin
                // Hold until the output register is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sa    = fpt_pkg::sat_sum(r_sa);
                    n_out_sb    = fpt_pkg::sat_sum(r_sb);
                    // Equal ratios: sigma(a) * b == sigma(b) * a, no zero input.
                    n_out_fr    = (r_a != '0) && (r_b != '0) && (r_pa == r_pb);
                    n_state     = fpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_d      <= n_d;
        r_sel    <= n_sel;
        r_acc    <= n_acc;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_out_sa <= n_out_sa;
        r_out_sb <= n_out_sb;
        r_out_fr <= n_out_fr;
    end

    assign o_valid              = r_out_valid;
    assign o_first_divisor_sum  = r_out_sa;
    assign o_second_divisor_sum = r_out_sb;
    assign o_is_friendly        = r_out_fr;

endmodule

// ===== sv/fpt_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module fpt_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  fpt_pkg::t_num    i_dividend,
    input  fpt_pkg::t_num    i_divisor,
    output fpt_pkg::t_div_res o_res
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [fpt_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    fpt_pkg::t_num              r_rem, n_rem;
    fpt_pkg::t_num              r_quo, n_quo;
    fpt_pkg::t_num              r_dvs, n_dvs;
    logic [fpt_pkg::NUMBER_BITS:0] shifted;
    logic [fpt_pkg::NUMBER_BITS:0] diff;

    assign shifted = {r_rem, r_quo[fpt_pkg::NUMBER_BITS-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = fpt_pkg::CNT_W'(fpt_pkg::NUMBER_BITS);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // Subtract when the shifted remainder covers the divisor.
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = diff[fpt_pkg::NUMBER_BITS-1:0];
                n_quo = {r_quo[fpt_pkg::NUMBER_BITS-2:0], 1'b1};
            end else begin
                n_rem = shifted[fpt_pkg::NUMBER_BITS-1:0];
                n_quo = {r_quo[fpt_pkg::NUMBER_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == fpt_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_res = '{done: r_done, quotient: r_quo, remainder: r_rem};

endmodule

// ===== sv/fpt_checker.sv =====
// Port-level checker for the friendly pair test unit, with its bind.
`include "assert_macros.svh"

module fpt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [fpt_pkg::OUT_W-1:0] o_first_divisor_sum,
    input logic [fpt_pkg::OUT_W-1:0] o_second_divisor_sum,
    input logic                      o_is_friendly,
    input logic                      o_valid,
    input logic                      i_ready
);

    logic [2*fpt_pkg::OUT_W:0] res_bus;
    logic                      sums_nonzero;

    assign res_bus      = {o_first_divisor_sum, o_second_divisor_sum, o_is_friendly};
    assign sums_nonzero = (o_first_divisor_sum != '0) && (o_second_divisor_sum != '0);

    // A stalled result holds.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(res_bus)))

    // A friendly pair never holds a zero, so neither sum is zero.
    `ASSERT_CLK(a_friendly_sums, i_clk, i_rst_n, (o_valid && o_is_friendly) |-> sums_nonzero)

    // Busy right after a transfer in.
    `ASSERT_CLK(a_busy_after_in, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)

    // Reset drops any pending result.
    `ASSERT_CLK_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind friendly_pair_test_unit fpt_checker u_fpt_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_valid              (i_valid),
    .o_ready              (o_ready),
    .o_first_divisor_sum  (o_first_divisor_sum),
    .o_second_divisor_sum (o_second_divisor_sum),
    .o_is_friendly        (o_is_friendly),
    .o_valid              (o_valid),
    .i_ready              (i_ready)
);
